/* hw/rtl/line_code_6b8b_decoder_macros.svh */
// ----------------------------------------------------------------------------
// line_code_6b8b_decoder_macros
// Assertion macros for the 6b/8b line decoder.
// Every macro samples on the rising edge of clk and is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef LINE_CODE_6B8B_DECODER_MACROS_SVH
`define LINE_CODE_6B8B_DECODER_MACROS_SVH

// Implication checked in the same cycle.
`define LC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line decoder same-cycle check failed");

// Implication checked in the cycle after the antecedent.
`define LC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line decoder next-cycle check failed");

`endif

/* hw/rtl/lc6b8b_pkg.sv */
// ----------------------------------------------------------------------------
// lc6b8b_pkg
// Shared types, phase codes and nibble maps of the 6b/8b line decoder.
// ----------------------------------------------------------------------------
package lc6b8b_pkg;

  // Slot of the next 6-bit value within a group of three bytes
  localparam logic [1:0] PH_SLOT0 = 2'd0;
  localparam logic [1:0] PH_SLOT1 = 2'd1;
  localparam logic [1:0] PH_SLOT2 = 2'd2;
  localparam logic [1:0] PH_SLOT3 = 2'd3;

  // Map entry that marks a nibble with no valid code
  localparam logic [6:0] NIB_BAD = 7'h40;

  // Most results one item can produce
  localparam logic [1:0] MAX_RESULTS = 2'd2;

  // One result transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       status;
    logic       run_last;
  } lc_result_t;

  // Packer outputs for the item at the input register
  typedef struct packed {
    logic [1:0] n;
    lc_result_t res0;
    lc_result_t res1;
    logic       discarding;
  } lc_pack_out_t;

  // High nibble map
  function automatic logic [6:0] hi_nib_map(input logic [3:0] nib);
    logic [6:0] v;
    case (nib)
      4'h3:    v = 7'h10;
      4'h5:    v = 7'h20;
      4'h6:    v = 7'h30;
      4'h9:    v = 7'h28;
      4'hA:    v = 7'h18;
      4'hB:    v = 7'h00;
      4'hC:    v = 7'h08;
      4'hD:    v = 7'h38;
      default: v = NIB_BAD;
    endcase
    return v;
  endfunction

  // Low nibble map
  function automatic logic [6:0] lo_nib_map(input logic [3:0] nib);
    logic [6:0] v;
    case (nib)
      4'h2:    v = 7'h07;
      4'h3:    v = 7'h02;
      4'h4:    v = 7'h00;
      4'h5:    v = 7'h04;
      4'h6:    v = 7'h06;
      4'h9:    v = 7'h05;
      4'hA:    v = 7'h03;
      4'hC:    v = 7'h01;
      default: v = NIB_BAD;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/lc6b8b_decode.sv */
// ----------------------------------------------------------------------------
// lc6b8b_decode
// Maps a line byte to a 6-bit value; flags bad nibbles or raw codes over 63.
// ----------------------------------------------------------------------------
module lc6b8b_decode
  import lc6b8b_pkg::*;
(
  input  logic       use_encoding,
  input  logic [7:0] code_byte,
  output logic [5:0] value,
  output logic       invalid
);

  logic [7:0] sum;

  // Sum of both nibble entries; a bad nibble pushes it to 64 or more
  assign sum = {1'b0, hi_nib_map(code_byte[7:4])} + {1'b0, lo_nib_map(code_byte[3:0])};

  always_comb begin
    if (use_encoding) begin
      value   = sum[5:0];
      invalid = |sum[7:6];
    end else begin
      value   = code_byte[5:0];
      invalid = |code_byte[7:6];
    end
  end

endmodule

/* hw/rtl/lc6b8b_pack.sv */
// ----------------------------------------------------------------------------
// lc6b8b_pack
// Packs 6-bit values four to three bytes, flushes on block end and skips
// the rest of a block after an invalid code.
// ----------------------------------------------------------------------------
module lc6b8b_pack
  import lc6b8b_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [5:0]   value,
  input  logic         invalid,
  input  logic         last,
  output lc_pack_out_t pk
);

  logic [1:0] phase, phase_next;
  logic [7:0] partial_byte, partial_byte_next;
  logic       partial_valid, partial_valid_next;
  logic       discarding, discarding_next;

  logic       has_byte;
  logic [7:0] done_byte;

  // Completed byte and new partial byte for the current slot
  always_comb begin
    // a pending partial byte means this value completes one
    has_byte           = partial_valid;
    done_byte          = 8'h00;
    phase_next         = phase;
    partial_byte_next  = partial_byte;
    partial_valid_next = 1'b1;
    case (phase)
      PH_SLOT0: begin
        partial_byte_next = {value, 2'b00};
        phase_next        = PH_SLOT1;
      end
      PH_SLOT1: begin
        done_byte         = partial_byte | {6'b0, value[5:4]};
        partial_byte_next = {value[3:0], 4'b0000};
        phase_next        = PH_SLOT2;
      end
      PH_SLOT2: begin
        done_byte         = partial_byte | {4'b0, value[5:2]};
        partial_byte_next = {value[1:0], 6'b000000};
        phase_next        = PH_SLOT3;
      end
      default: begin
        done_byte          = partial_byte | {2'b0, value};
        partial_byte_next  = 8'h00;
        partial_valid_next = 1'b0;
        phase_next         = PH_SLOT0;
      end
    endcase
  end

  // Results of this item and the state it leaves
  always_comb begin
    pk.discarding   = discarding;
    pk.n            = 2'd0;
    pk.res0         = '0;
    pk.res1         = '0;
    discarding_next = discarding;
    if (discarding) begin
      if (last) begin
        discarding_next = 1'b0;
      end
    end else if (invalid) begin
      pk.n            = 2'd1;
      pk.res0         = '{data_byte: 8'h00, status: 1'b1, run_last: 1'b1};
      discarding_next = !last;
    end else if (has_byte) begin
      pk.res0 = '{data_byte: done_byte, status: 1'b0, run_last: 1'b0};
      if (last && partial_valid_next) begin
        pk.n    = MAX_RESULTS;
        pk.res1 = '{data_byte: partial_byte_next, status: 1'b0, run_last: 1'b1};
      end else begin
        pk.n             = 2'd1;
        pk.res0.run_last = last;
      end
    end else if (last) begin
      // first slot of a group: only the flushed partial byte
      pk.n    = 2'd1;
      pk.res0 = '{data_byte: partial_byte_next, status: 1'b0, run_last: 1'b1};
    end
  end

  // State update on each consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SLOT0;
      partial_byte  <= 8'h00;
      partial_valid <= 1'b0;
      discarding    <= 1'b0;
    end else if (fire) begin
      discarding <= discarding_next;
      if (!discarding) begin
        if (invalid || last) begin
          phase         <= PH_SLOT0;
          partial_byte  <= 8'h00;
          partial_valid <= 1'b0;
        end else begin
          phase         <= phase_next;
          partial_byte  <= partial_byte_next;
          partial_valid <= partial_valid_next;
        end
      end
    end
  end

endmodule

/* hw/rtl/lc6b8b_outq.sv */
// ----------------------------------------------------------------------------
// lc6b8b_outq
// Two-entry result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module lc6b8b_outq
  import lc6b8b_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  lc_result_t res0,
  input  lc_result_t res1,
  input  logic       pop,
  output lc_result_t head,
  output logic [1:0] fill
);

  lc_result_t entry [2];
  logic       rd_ptr;
  logic       wr_ptr;

  assign head = entry[rd_ptr];

  // Result storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry[wr_ptr] <= res0;
    end
    if (push_n == MAX_RESULTS) begin
      entry[!wr_ptr] <= res1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      rd_ptr <= rd_ptr ^ pop;
      wr_ptr <= wr_ptr ^ push_n[0];
      fill   <= fill - {1'b0, pop} + push_n;
    end
  end

endmodule

/* hw/rtl/line_code_6b8b_decoder.sv */
// ----------------------------------------------------------------------------
// line_code_6b8b_decoder: 6b/8b line byte decoder and 6-to-8 bit packer
// An accepted item passes the input register, then the result queue; one item per
// cycle while the 2-entry queue fits its results; they leave one per unstalled cycle.
// Synchronous reset: empty pipeline, packer cleared, use_encoding set to 1.
// ----------------------------------------------------------------------------
`include "line_code_6b8b_decoder_macros.svh"

module line_code_6b8b_decoder
  import lc6b8b_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic       cfg_data,
  // line byte channel
  input  logic       code_valid,
  output logic       code_stall,
  input  logic [7:0] code_byte,
  input  logic       block_end,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] data_byte,
  output logic       status,
  output logic       run_last
);

  logic         use_encoding;
  logic         in_full;
  logic [7:0]   in_code;
  logic         in_last;
  logic [5:0]   value;
  logic         invalid;
  lc_pack_out_t pk;
  lc_result_t   head;
  logic [1:0]   fill;
  logic         pop;
  logic [2:0]   fill_after;
  logic         consume;
  logic [1:0]   push_n;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      use_encoding <= 1'b1;
    end else if (cfg_write) begin
      use_encoding <= cfg_data;
    end
  end

  // Queue room check: item leaves the input register only if all results fit
  assign pop        = result_valid && !result_stall;
  assign fill_after = {1'b0, fill} - {2'b0, pop} + {1'b0, pk.n};
  assign consume    = in_full && (fill_after <= {1'b0, MAX_RESULTS});
  assign push_n     = consume ? pk.n : 2'd0;
  assign code_stall = in_full && !consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!code_stall) begin
      in_full <= code_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!code_stall && code_valid) begin
      in_code <= code_byte;
      in_last <= block_end;
    end
  end

  lc6b8b_decode u_decode (
    .use_encoding (use_encoding),
    .code_byte    (in_code),
    .value        (value),
    .invalid      (invalid)
  );

  lc6b8b_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .fire    (consume),
    .value   (value),
    .invalid (invalid),
    .last    (in_last),
    .pk      (pk)
  );

  lc6b8b_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .res0   (pk.res0),
    .res1   (pk.res1),
    .pop    (pop),
    .head   (head),
    .fill   (fill)
  );

  // Result port
  assign result_valid = (fill != 2'd0);
  assign data_byte    = head.data_byte;
  assign status       = head.status;
  assign run_last     = head.run_last;

  // Checks
  `LC_ASSERT_IMPL(a_fill_bound, 1'b1, fill <= MAX_RESULTS)
  `LC_ASSERT_IMPL(a_pair_room, consume && pk.n == MAX_RESULTS,
                  fill == 2'd0 || (fill == 2'd1 && pop))
  `LC_ASSERT_IMPL(a_block_close, consume && in_last && !pk.discarding,
                  (pk.n == 2'd1 && pk.res0.run_last) ||
                  (pk.n == MAX_RESULTS && pk.res1.run_last && !pk.res0.run_last))
  `LC_ASSERT_NEXT(a_push_shows, consume && pk.n != 2'd0, result_valid)

endmodule
